// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/nfsi_pkg.sv =====
package nfsi_pkg;

    localparam int ROW_W = 32;
    localparam int BIT_W = 5;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOSLOT  = 2'd3
    } status_t;

endpackage

// ===== sv/nfsi_if.sv =====
interface nfsi_req_if;
    logic               valid;
    logic               ready;
    logic signed [8:0]  position;
    logic signed [31:0] value;

    modport source (output valid, output position, output value, input ready);
    modport sink (input valid, input position, input value, output ready);
endinterface

interface nfsi_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] slot_used;
    logic [7:0] entry_count;

    modport source (output valid, output status, output slot_used, output entry_count,
                    input ready);
    modport sink (input valid, input status, input slot_used, input entry_count,
                  output ready);
endinterface

// ===== sv/nearest_free_slot_insert.sv =====
// Insert unit for a table of DEPTH slots: each request word names a wanted slot and a value,
// and the value lands in the wanted slot if it is empty, else in the nearest empty slot,
// with the lower neighbor winning a tie. Only whether a slot is empty is kept, as one bit
// per slot in a memory of 32-bit rows with two read ports; the table is empty after reset.
// A rejected request (position outside the table, or table full) skips the scan and goes
// straight to its result. A request that is not rejected first runs a scan that walks down
// and up from the wanted row, one row each way per cycle. Each direction stops at its first
// free slot or at the table edge, and the scan ends when the direction that stops last has
// stopped; each direction reads at most ceil(DEPTH/32) rows. One request is in flight at a
// time, and a finished result word waits in an output register while the next request is
// taken; a request whose result is ready stays in its last cycle until that register is free.
module nearest_free_slot_insert #(
    parameter int DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    nfsi_req_if.sink   req,
    nfsi_rsp_if.source rsp
);

    localparam int ROW_W     = nfsi_pkg::ROW_W;
    localparam int BIT_W     = nfsi_pkg::BIT_W;
    localparam int ROWS      = (DEPTH + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int GW        = ROW_AW + BIT_W;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LAST_BITS = DEPTH - (ROWS - 1) * ROW_W;
    localparam logic [ROW_W-1:0] LAST_MASK = ROW_W'((64'h1 << LAST_BITS) - 64'h1);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    function automatic logic [BIT_W-1:0] msb_of(input logic [ROW_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            if (v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [BIT_W-1:0] lsb_of(input logic [ROW_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    logic [ROW_W-1:0] occ_mem [ROWS];

    state_t              state_reg;
    logic [GW-1:0]       pos_reg;
    logic                nz_reg;
    logic                reject_reg;
    nfsi_pkg::status_t   rej_status_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ROWS-1:0]     row_valid_reg;

    logic [ROW_W-1:0]    lo_rdata_reg, hi_rdata_reg;
    logic                lo_rv_reg, hi_rv_reg;
    logic [ROW_AW-1:0]   lo_row_reg, hi_row_reg;

    logic                lo_done_reg, lo_found_reg, hi_done_reg, hi_found_reg;
    logic [GW-1:0]       lo_idx_reg, hi_idx_reg;
    logic [ROW_W-1:0]    lo_fdata_reg, hi_fdata_reg;

    logic                out_valid_reg;
    nfsi_pkg::status_t   out_status_reg;
    logic [6:0]          out_slot_reg;
    logic [7:0]          out_count_reg;

    logic                req_fire;
    logic                req_pos_ok;
    logic                req_full;
    logic [GW-1:0]       req_pos;
    logic [ROW_AW-1:0]   lo_raddr, hi_raddr;

    logic [ROW_AW-1:0]   pos_row;
    logic [BIT_W-1:0]    pos_bit;
    logic [ROW_W-1:0]    lo_data, hi_data;
    logic [ROW_W-1:0]    lo_mask, hi_mask;
    logic [ROW_W-1:0]    lo_free, hi_free;
    logic                lo_done_next, hi_done_next;

    logic [GW-1:0]       dist_lo, dist_hi;
    logic                take_lo, any_found;
    logic [GW-1:0]       target;
    logic [ROW_W-1:0]    target_data;
    logic                out_free;
    logic                out_load;
    logic                mem_we;
    logic [CNT_W-1:0]    count_inc;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign req_pos_ok = !req.position[8] && (32'(req.position[7:0]) < 32'(DEPTH));
    assign req_full   = (count_reg == FULL_COUNT);
    assign req_pos    = GW'(req.position[7:0]);

    assign pos_row = pos_reg[GW-1:BIT_W];
    assign pos_bit = pos_reg[BIT_W-1:0];

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            lo_raddr = req_pos_ok ? req_pos[GW-1:BIT_W] : '0;
            hi_raddr = lo_raddr;
        end
        else
        begin
            lo_raddr = (lo_row_reg == '0) ? lo_row_reg : lo_row_reg - 1'b1;
            hi_raddr = (hi_row_reg == LAST_ROW) ? hi_row_reg : hi_row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[target[GW-1:BIT_W]] <= target_data | (ROW_W'(1) << target[BIT_W-1:0]);
        end
        lo_rdata_reg <= occ_mem[lo_raddr];
        hi_rdata_reg <= occ_mem[hi_raddr];
        lo_rv_reg    <= row_valid_reg[lo_raddr];
        hi_rv_reg    <= row_valid_reg[hi_raddr];
        lo_row_reg   <= lo_raddr;
        hi_row_reg   <= hi_raddr;
    end

    // A row that was never written reads as all empty.
    assign lo_data = lo_rv_reg ? lo_rdata_reg : '0;
    assign hi_data = hi_rv_reg ? hi_rdata_reg : '0;

    // The lower scan covers the wanted slot itself, the upper scan only slots above it.
    always_comb
    begin
        lo_mask = (lo_row_reg == pos_row) ? ({ROW_W{1'b1}} >> (BIT_W'(ROW_W - 1) - pos_bit))
                                          : {ROW_W{1'b1}};
        hi_mask = (hi_row_reg == pos_row) ? ({{(ROW_W-1){1'b1}}, 1'b0} << pos_bit)
                                          : {ROW_W{1'b1}};
        if (hi_row_reg == LAST_ROW)
        begin
            hi_mask = hi_mask & LAST_MASK;
        end
    end

    assign lo_free = ~lo_data & lo_mask;
    assign hi_free = ~hi_data & hi_mask;

    assign lo_done_next = lo_done_reg || (|lo_free) || (lo_row_reg == '0);
    assign hi_done_next = hi_done_reg || (|hi_free) || (hi_row_reg == LAST_ROW);

    assign dist_lo     = pos_reg - lo_idx_reg;
    assign dist_hi     = hi_idx_reg - pos_reg;
    assign take_lo     = lo_found_reg && (!hi_found_reg || (dist_lo <= dist_hi));
    assign any_found   = lo_found_reg || hi_found_reg;
    assign target      = take_lo ? lo_idx_reg : hi_idx_reg;
    assign target_data = take_lo ? lo_fdata_reg : hi_fdata_reg;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign out_load    = (state_reg == S_DECIDE) && out_free;
    assign mem_we      = (state_reg == S_DECIDE) && out_free && !reject_reg && any_found
                         && nz_reg;
    assign count_inc   = count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            nz_reg         <= 1'b0;
            reject_reg     <= 1'b0;
            rej_status_reg <= nfsi_pkg::ST_INVALID;
            count_reg      <= '0;
            row_valid_reg  <= '0;
            lo_done_reg    <= 1'b0;
            lo_found_reg   <= 1'b0;
            hi_done_reg    <= 1'b0;
            hi_found_reg   <= 1'b0;
            lo_idx_reg     <= '0;
            hi_idx_reg     <= '0;
            lo_fdata_reg   <= '0;
            hi_fdata_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= nfsi_pkg::ST_STORED;
            out_slot_reg   <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        pos_reg        <= req_pos;
                        nz_reg         <= |req.value;
                        reject_reg     <= !req_pos_ok || req_full;
                        rej_status_reg <= !req_pos_ok ? nfsi_pkg::ST_INVALID
                                                      : nfsi_pkg::ST_FULL;
                        lo_done_reg    <= 1'b0;
                        lo_found_reg   <= 1'b0;
                        hi_done_reg    <= 1'b0;
                        hi_found_reg   <= 1'b0;
                        state_reg      <= (!req_pos_ok || req_full) ? S_DECIDE : S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (!lo_done_reg)
                    begin
                        lo_done_reg <= lo_done_next;
                        if (|lo_free)
                        begin
                            lo_found_reg <= 1'b1;
                            lo_idx_reg   <= {lo_row_reg, msb_of(lo_free)};
                            lo_fdata_reg <= lo_data;
                        end
                    end
                    if (!hi_done_reg)
                    begin
                        hi_done_reg <= hi_done_next;
                        if (|hi_free)
                        begin
                            hi_found_reg <= 1'b1;
                            hi_idx_reg   <= {hi_row_reg, lsb_of(hi_free)};
                            hi_fdata_reg <= hi_data;
                        end
                    end
                    if (lo_done_next && hi_done_next)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (reject_reg)
                        begin
                            out_status_reg <= rej_status_reg;
                            out_slot_reg   <= '0;
                            out_count_reg  <= 8'(count_reg);
                        end
                        else if (any_found)
                        begin
                            out_status_reg <= nfsi_pkg::ST_STORED;
                            out_slot_reg   <= 7'(target);
                            out_count_reg  <= 8'(count_inc);
                            count_reg      <= count_inc;
                            if (nz_reg)
                            begin
                                row_valid_reg[target[GW-1:BIT_W]] <= 1'b1;
                            end
                        end
                        else
                        begin
                            out_status_reg <= nfsi_pkg::ST_NOSLOT;
                            out_slot_reg   <= '0;
                            out_count_reg  <= 8'(count_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot_used   = out_slot_reg;
    assign rsp.entry_count = out_count_reg;

endmodule

// ===== sv/nfsi_checker.sv =====
`include "assert_macros.svh"

module nfsi_checker #(
    parameter int DEPTH = 128
) (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [6:0] rsp_slot_used,
    input logic [7:0] rsp_entry_count
);

    // A word held back by the sink keeps its fields.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot_used) && $stable(rsp_entry_count))

    // Only one request is worked on at a time.
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // A request that stored nothing reports slot zero.
    `ASSERT_SAME(a_slot_zero, clk, rst_n, rsp_valid && (rsp_status != nfsi_pkg::ST_STORED), rsp_slot_used == 7'd0)

    // A full table is reported only when the count has reached the depth.
    `ASSERT_SAME(a_full_count, clk, rst_n, rsp_valid && (rsp_status == nfsi_pkg::ST_FULL), rsp_entry_count == 8'(DEPTH))

endmodule

bind nearest_free_slot_insert nfsi_checker #(.DEPTH(DEPTH)) u_nfsi_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_slot_used   (rsp.slot_used),
    .rsp_entry_count (rsp.entry_count)
);
